// ===== sv/adp_pkg.sv =====
// shared types and codes for the data-processing alu
`default_nettype none
package adp_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } adp_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } adp_shift_t;

  localparam logic [3:0] PC_INDEX = 4'd15;
  localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } adp_flags_t;

  typedef struct packed {
    adp_op_t    func;
    logic       set_flags;
    logic       shift_by_register;
    adp_shift_t shift_type;
    logic [4:0] shift_immediate;
    logic [3:0] dest_index;
    logic [31:0] first_operand;
    logic [31:0] shift_source;
    logic [7:0] shift_register_byte;
    adp_flags_t saved_flags;
    logic       has_saved_status;
  } adp_instr_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_enable;
    adp_flags_t  flags;
  } adp_res_t;

endpackage
`default_nettype wire

// ===== sv/adp_alu.sv =====
// barrel shifter, alu and flag update for one instruction
`default_nettype none
module adp_alu
  import adp_pkg::*;
(
  input  adp_instr_t instr,
  input  adp_flags_t flags_in,
  output adp_res_t   res
);

  logic [7:0]  amt;
  logic        rrx;
  logic        pass;
  logic [31:0] rm;
  logic [31:0] op2;
  logic        sh_c;
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic [32:0] asr_ext;
  logic [63:0] ror_ext;
  logic        big;
  logic        is32;
  logic [31:0] add_x;
  logic [31:0] add_y;
  logic        add_ci;
  logic [32:0] sum;
  logic        arith;
  logic        compare;
  logic [31:0] r;
  adp_flags_t  nf;

  // shift amount, with the immediate-zero encodings resolved
  always_comb begin
    rm   = instr.shift_source;
    rrx  = 1'b0;
    amt  = instr.shift_register_byte;
    if (!instr.shift_by_register) begin
      amt = {3'd0, instr.shift_immediate};
      if (instr.shift_immediate == 5'd0) begin
        case (instr.shift_type)
          SH_LSR, SH_ASR: amt = 8'd32;
          SH_ROR:         rrx = 1'b1;
          default:        amt = 8'd0;
        endcase
      end
    end
    pass = (amt == 8'd0);
    big  = (amt[7:5] != 3'd0);
    is32 = (amt == 8'd32);
  end

  assign lsl_ext = {1'b0, rm} << amt[4:0];
  assign lsr_ext = {rm, 1'b0} >> amt[4:0];
  assign asr_ext = 33'($signed({rm, 1'b0}) >>> amt[4:0]);
  assign ror_ext = {rm, rm} >> amt[4:0];

  always_comb begin
    op2  = rm;
    sh_c = flags_in.c;
    if (rrx) begin
      op2  = {flags_in.c, rm[31:1]};
      sh_c = rm[0];
    end else if (!pass) begin
      case (instr.shift_type)
        SH_LSL: begin
          if (!big) begin
            op2 = lsl_ext[31:0]; sh_c = lsl_ext[32];
          end else begin
            op2 = '0; sh_c = is32 ? rm[0] : 1'b0;
          end
        end
        SH_LSR: begin
          if (!big) begin
            op2 = lsr_ext[32:1]; sh_c = lsr_ext[0];
          end else begin
            op2 = '0; sh_c = is32 ? rm[31] : 1'b0;
          end
        end
        SH_ASR: begin
          if (!big) begin
            op2 = asr_ext[32:1]; sh_c = asr_ext[0];
          end else begin
            op2 = rm[31] ? FULL_WORD : '0; sh_c = rm[31];
          end
        end
        default: begin
          op2 = ror_ext[31:0]; sh_c = ror_ext[31];
        end
      endcase
    end
  end

  // one shared adder for all arithmetic opcodes
  always_comb begin
    add_x  = instr.first_operand;
    add_y  = op2;
    add_ci = 1'b0;
    case (instr.func)
      OP_SUB, OP_CMP: begin add_y = ~op2; add_ci = 1'b1; end
      OP_RSB: begin add_x = op2; add_y = ~instr.first_operand; add_ci = 1'b1; end
      OP_ADC: add_ci = flags_in.c;
      OP_SBC: begin add_y = ~op2; add_ci = flags_in.c; end
      OP_RSC: begin add_x = op2; add_y = ~instr.first_operand; add_ci = flags_in.c; end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};

  always_comb begin
    arith = 1'b0;
    case (instr.func)
      OP_AND, OP_TST: r = instr.first_operand & op2;
      OP_EOR, OP_TEQ: r = instr.first_operand ^ op2;
      OP_ORR:         r = instr.first_operand | op2;
      OP_MOV:         r = op2;
      OP_BIC:         r = instr.first_operand & ~op2;
      OP_MVN:         r = ~op2;
      default: begin
        r = sum[31:0]; arith = 1'b1;
      end
    endcase
    compare = (instr.func == OP_TST) || (instr.func == OP_TEQ) ||
              (instr.func == OP_CMP) || (instr.func == OP_CMN);
    nf.n = r[31];
    nf.z = (r == 32'd0);
    nf.c = arith ? sum[32] : sh_c;
    nf.v = arith ? ((add_x[31] ^ r[31]) & (add_y[31] ^ r[31])) : flags_in.v;

    res.flags = flags_in;
    if (compare) begin
      res.flags = nf;
    end else if (instr.set_flags) begin
      if (instr.dest_index == PC_INDEX) begin
        if (instr.has_saved_status) res.flags = instr.saved_flags;
      end else begin
        res.flags = nf;
      end
    end
    res.result       = compare ? 32'd0 : r;
    res.write_enable = !compare;
  end

endmodule
`default_nettype wire

// ===== sv/arm_data_processing_alu_unit.sv =====
// top level: data-processing alu with input and result registers
// One transaction in, one transaction out. An accepted instruction sits in an
// input register; on the next edge at which the result register is free (or
// being taken) it passes through the shifter and alu and lands in the result
// register, and the NZCV register is updated at that same edge. Sustained
// rate is one instruction per cycle while out_ready does not stall the result
// register; out_valid rises once the instruction has moved from the input
// register into the result register. The carry-in of each instruction is the
// NZCV value left by the one before it, which is why flag update and result
// capture share one edge. After reset the flags are all zero.
`default_nettype none
module arm_data_processing_alu_unit
  import adp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_func,
  input  wire logic        in_set_flags,
  input  wire logic        in_shift_by_register,
  input  wire logic [1:0]  in_shift_type,
  input  wire logic [4:0]  in_shift_immediate,
  input  wire logic [3:0]  in_dest_index,
  input  wire logic [31:0] in_first_operand,
  input  wire logic [31:0] in_shift_source,
  input  wire logic [7:0]  in_shift_register_byte,
  input  wire logic [3:0]  in_saved_flags,
  input  wire logic        in_has_saved_status,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_result,
  output logic             out_write_enable,
  output logic [3:0]       out_flags_out
);

  // input register stage
  logic       ivalid_r, ivalid_nxt;
  adp_instr_t instr_r;
  // result register stage
  logic       ovalid_r, ovalid_nxt;
  adp_res_t   res_r;
  adp_res_t   res_nxt;
  // architectural flags
  adp_flags_t flags_r;

  logic advance;
  logic in_take;

  // the input stage moves on whenever the result register can take it
  assign advance  = ivalid_r && (!ovalid_r || out_ready);
  assign in_ready = !ivalid_r || advance;
  assign in_take  = in_valid && in_ready;

  adp_alu u_alu (
    .instr    (instr_r),
    .flags_in (flags_r),
    .res      (res_nxt)
  );

  always_comb begin
    ivalid_nxt = in_take || (ivalid_r && !advance);
    ovalid_nxt = advance || (ovalid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivalid_r <= 1'b0;
      ovalid_r <= 1'b0;
      flags_r  <= '0;
    end else begin
      ivalid_r <= ivalid_nxt;
      ovalid_r <= ovalid_nxt;
      // flags change exactly when an instruction retires into the result stage
      if (advance) flags_r <= res_nxt.flags;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      instr_r.func                <= adp_op_t'(in_func);
      instr_r.set_flags           <= in_set_flags;
      instr_r.shift_by_register   <= in_shift_by_register;
      instr_r.shift_type          <= adp_shift_t'(in_shift_type);
      instr_r.shift_immediate     <= in_shift_immediate;
      instr_r.dest_index          <= in_dest_index;
      instr_r.first_operand       <= in_first_operand;
      instr_r.shift_source        <= in_shift_source;
      instr_r.shift_register_byte <= in_shift_register_byte;
      instr_r.saved_flags         <= adp_flags_t'(in_saved_flags);
      instr_r.has_saved_status    <= in_has_saved_status;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid        = ovalid_r;
  assign out_result       = res_r.result;
  assign out_write_enable = res_r.write_enable;
  assign out_flags_out    = res_r.flags;

endmodule
`default_nettype wire
